>>> design/cdq_pkg.sv
// shared types and constants for the circular deque unit
`timescale 1ns / 1ps

package cdq_pkg;

	// fixed field widths
	localparam int DATA_W = 32;
	localparam int ACT_W  = 3;
	localparam int STS_W  = 2;
	localparam int CAP_W  = 7;

	// default store depth and capacity after reset
	localparam int          DEPTH_DEFAULT = 64;
	localparam logic [6:0]  CAP_RESET     = 7'd64;

	// action codes
	localparam logic [2:0] ACT_INS_FRONT = 3'd0;
	localparam logic [2:0] ACT_INS_REAR  = 3'd1;
	localparam logic [2:0] ACT_RM_FRONT  = 3'd2;
	localparam logic [2:0] ACT_RM_REAR   = 3'd3;
	localparam logic [2:0] ACT_READ_ALL  = 3'd4;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// read address select
	typedef enum logic [1:0] {
		RD_HEAD = 2'd0,
		RD_TAIL = 2'd1,
		RD_ITER = 2'd2
	} rd_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    latch;
		logic    ins;
		logic    err;
		status_t err_code;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    rm;
		logic    ro;
		logic    ld;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [2:0] act;
		logic       empty;
		logic       full;
		logic       out_free;
		logic       rd_last;
	} sts_t;

endpackage

>>> design/cdq_ctrl.sv
// controller state machine of the circular deque unit
`timescale 1ns / 1ps

module cdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          cfg_ready,
	input  cdq_pkg::sts_t sts,
	output cdq_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	state_t state_q;
	state_t state_nx;

	// handshake side
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.err_code = cdq_pkg::ST_OK;
		cmd.rd_sel   = cdq_pkg::RD_HEAD;
		state_nx     = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nx  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.act)
					cdq_pkg::ACT_INS_FRONT, cdq_pkg::ACT_INS_REAR: begin
						if (sts.out_free) begin
							if (sts.full) begin
								cmd.err      = 1'b1;
								cmd.err_code = cdq_pkg::ST_OVERFLOW;
							end else begin
								cmd.ins = 1'b1;
							end
							state_nx = S_IDLE;
						end
					end
					cdq_pkg::ACT_RM_FRONT, cdq_pkg::ACT_RM_REAR: begin
						if (sts.empty) begin
							if (sts.out_free) begin
								cmd.err      = 1'b1;
								cmd.err_code = cdq_pkg::ST_UNDERFLOW;
								state_nx     = S_IDLE;
							end
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rm     = 1'b1;
							cmd.rd_sel = (sts.act == cdq_pkg::ACT_RM_FRONT) ?
								cdq_pkg::RD_HEAD : cdq_pkg::RD_TAIL;
							state_nx   = S_LOAD;
						end
					end
					cdq_pkg::ACT_READ_ALL: begin
						if (sts.empty) begin
							if (sts.out_free) begin
								cmd.err      = 1'b1;
								cmd.err_code = cdq_pkg::ST_EMPTY;
								state_nx     = S_IDLE;
							end
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.ro     = 1'b1;
							cmd.rd_sel = cdq_pkg::RD_HEAD;
							state_nx   = S_LOAD;
						end
					end
					default: begin
						state_nx = S_IDLE;
					end
				endcase
			end
			S_LOAD: begin
				// hand read data to the output register, fetch the next entry of a read-out
				if (sts.out_free) begin
					cmd.ld = 1'b1;
					if (sts.rd_last) begin
						state_nx = S_IDLE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.ro     = 1'b1;
						cmd.rd_sel = cdq_pkg::RD_ITER;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

>>> design/cdq_dp.sv
// datapath of the circular deque unit: store, indices, output register
`timescale 1ns / 1ps

module cdq_dp #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [cdq_pkg::ACT_W-1:0]         action,
	input  logic signed [cdq_pkg::DATA_W-1:0] value_in,
	input  logic                              cfg_wr,
	input  logic [cdq_pkg::CAP_W-1:0]         capacity,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic signed [cdq_pkg::DATA_W-1:0] value_out,
	output logic [cdq_pkg::STS_W-1:0]         status,
	output logic                              last,
	input  cdq_pkg::cmd_t                     cmd,
	output cdq_pkg::sts_t                     sts
);

	localparam int AW = $clog2(DEPTH);
	localparam int EW = (AW + 1 > cdq_pkg::CAP_W) ? AW + 1 : cdq_pkg::CAP_W;

	logic [cdq_pkg::DATA_W-1:0] entry_mem [DEPTH];

	logic [cdq_pkg::CAP_W-1:0]  cap_q;
	logic [AW-1:0]              head_q;
	logic [AW-1:0]              tail_q;
	logic                       empty_q;
	logic [cdq_pkg::ACT_W-1:0]  act_q;
	logic [cdq_pkg::DATA_W-1:0] val_q;
	logic [AW-1:0]              iter_q;
	logic [AW-1:0]              cnt_q;
	logic                       rd_last_q;
	logic [cdq_pkg::DATA_W-1:0] rd_data_q;
	logic                       out_valid_q;
	logic [cdq_pkg::DATA_W-1:0] value_out_q;
	logic [cdq_pkg::STS_W-1:0]  status_q;
	logic                       last_q;

	logic [AW-1:0] capm1;
	logic [AW-1:0] head_nx;
	logic [AW-1:0] head_pv;
	logic [AW-1:0] tail_nx;
	logic [AW-1:0] tail_pv;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] rd_addr_nx;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] ro_k;
	logic          ro_end;
	logic          out_free;

	// last index in use, capacity clamped to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			capm1 = '0;
		end else if (EW'(cap_q) > EW'(DEPTH)) begin
			capm1 = AW'(DEPTH - 1);
		end else begin
			capm1 = AW'(EW'(cap_q) - EW'(1));
		end
	end

	// circular neighbors of head and tail
	assign head_nx = (head_q == capm1) ? '0 : head_q + 1'b1;
	assign head_pv = (head_q == '0) ? capm1 : head_q - 1'b1;
	assign tail_nx = (tail_q == capm1) ? '0 : tail_q + 1'b1;
	assign tail_pv = (tail_q == '0) ? capm1 : tail_q - 1'b1;

	// read address and read-out end detection
	always_comb begin
		case (cmd.rd_sel)
			cdq_pkg::RD_HEAD: rd_addr = head_q;
			cdq_pkg::RD_TAIL: rd_addr = tail_q;
			cdq_pkg::RD_ITER: rd_addr = iter_q;
			default:          rd_addr = head_q;
		endcase
	end
	assign rd_addr_nx = (rd_addr == capm1) ? '0 : rd_addr + 1'b1;
	assign ro_k       = (cmd.rd_sel == cdq_pkg::RD_HEAD) ? '0 : cnt_q;
	assign ro_end     = (rd_addr == tail_q) || (ro_k == capm1);

	// insert position
	always_comb begin
		if (empty_q) begin
			wr_addr = '0;
		end else if (act_q == cdq_pkg::ACT_INS_FRONT) begin
			wr_addr = head_pv;
		end else begin
			wr_addr = tail_nx;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// status toward the controller
	assign sts.act      = act_q;
	assign sts.empty    = empty_q;
	assign sts.full     = !empty_q && (tail_nx == head_q);
	assign sts.out_free = out_free;
	assign sts.rd_last  = rd_last_q;

	// capacity and indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= cdq_pkg::CAP_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cfg_wr) begin
			cap_q   <= capacity;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.ins) begin
			if (empty_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b0;
			end else if (act_q == cdq_pkg::ACT_INS_FRONT) begin
				head_q <= head_pv;
			end else begin
				tail_q <= tail_nx;
			end
		end else if (cmd.rm) begin
			if (head_q == tail_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b1;
			end else if (act_q == cdq_pkg::ACT_RM_FRONT) begin
				head_q <= head_nx;
			end else begin
				tail_q <= tail_pv;
			end
		end
	end

	// item capture and read-out walk
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q <= action;
			val_q <= value_in;
		end
		if (cmd.rd_en) begin
			rd_last_q <= cmd.ro ? ro_end : 1'b1;
		end
		if (cmd.rd_en && cmd.ro) begin
			iter_q <= rd_addr_nx;
			cnt_q  <= ro_k + 1'b1;
		end
	end

	// entry store with registered read
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			entry_mem[wr_addr] <= val_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= entry_mem[rd_addr];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ins || cmd.err || cmd.ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			value_out_q <= rd_data_q;
			status_q    <= cdq_pkg::ST_OK;
			last_q      <= rd_last_q;
		end else if (cmd.err) begin
			value_out_q <= '0;
			status_q    <= cmd.err_code;
			last_q      <= 1'b1;
		end else if (cmd.ins) begin
			value_out_q <= '0;
			status_q    <= cdq_pkg::ST_OK;
			last_q      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign last      = last_q;

	// indices stay inside the capacity in use
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= capm1) && (tail_q <= capm1))
		else $error("deque index beyond capacity");

	// an empty deque has both indices at zero
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0) && (tail_q == '0))
		else $error("empty deque with nonzero index");

	// one source loads the output register, and only when it is free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins || cmd.err || cmd.ld) |-> $onehot({cmd.ins, cmd.err, cmd.ld}) && out_free)
		else $error("output register overwritten");

endmodule

>>> design/circular_deque_unit.sv
// Double-ended queue in a circular store, top level.
// Input channel: in_valid/in_stall with action and value_in; a transfer takes
// place when in_valid is high and in_stall is low. Output channel: out_valid/
// out_stall with value_out, status and last; every item but an unused action gives one result, a
// read-out of a non-empty deque one result per entry, front first, last marked.
// Configuration: cfg_valid/cfg_ready carrying capacity; a write empties the deque.
// An insert or error result is loaded into the output register in the execute
// state after its transfer, once the register is free. A remove result and each
// read-out entry pass through the registered read of the entry store and are
// loaded in the load state; a read-out then gives one entry per cycle while the
// receiver does not stall. The controller takes one item at a time: the next
// transfer is possible in the cycle after the item's last result is loaded.
// Unused actions give no result.
// Reset: deque empty, capacity 64, indices zero; store contents undefined.
// While the receiver stalls, the output register holds its result and the
// block waits before loading the next one; a read-out pauses in place.
`timescale 1ns / 1ps

module circular_deque_unit #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cdq_pkg::ACT_W-1:0]         action,
	input  logic signed [cdq_pkg::DATA_W-1:0] value_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [cdq_pkg::DATA_W-1:0] value_out,
	output logic [cdq_pkg::STS_W-1:0]         status,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0]         capacity
);

	cdq_pkg::cmd_t cmd;
	cdq_pkg::sts_t sts;
	logic          cfg_wr;

	// configuration transfer
	assign cfg_wr = cfg_valid && cfg_ready;

	// controller
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	cdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.action    (action),
		.value_in  (value_in),
		.cfg_wr    (cfg_wr),
		.capacity  (capacity),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.value_out (value_out),
		.status    (status),
		.last      (last),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> test/tb.sv
// self-checking testbench for the circular deque unit
`timescale 1ns / 1ps

module tb;

	localparam int STORE_DEPTH = cdq_pkg::DEPTH_DEFAULT;
	localparam logic [cdq_pkg::ACT_W-1:0] ACT_FIRST_UNUSED = cdq_pkg::ACT_READ_ALL + 3'd1;
	localparam logic [cdq_pkg::ACT_W-1:0] ACT_MAX = 3'd7;
	localparam int SIDE_IN = 0;
	localparam int SIDE_OUT = 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	typedef logic [cdq_pkg::ACT_W-1:0] act_val_t;
	typedef logic [cdq_pkg::CAP_W-1:0] cap_val_t;

	// one request to the deque
	typedef struct {
		logic [cdq_pkg::ACT_W-1:0]         act;
		logic signed [cdq_pkg::DATA_W-1:0] val;
		bit                                hold;
	} deque_op_t;

	// one predicted response
	typedef struct {
		logic signed [cdq_pkg::DATA_W-1:0] value;
		cdq_pkg::status_t                  st;
		logic                              last;
	} deque_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [cdq_pkg::ACT_W-1:0]         action = '0;
	logic signed [cdq_pkg::DATA_W-1:0] value_in = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [cdq_pkg::DATA_W-1:0] value_out;
	logic [cdq_pkg::STS_W-1:0]         status;
	logic                              last;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [cdq_pkg::CAP_W-1:0]         capacity = cdq_pkg::CAP_RESET;

	deque_op_t     pending_ops[$];
	deque_result_t predicted_results[$];
	logic          results_drained = 1'b1;

	// shadow copy of the deque state
	logic [cdq_pkg::DATA_W-1:0] shadow_store [STORE_DEPTH];
	int unsigned                shadow_front;
	int unsigned                shadow_rear;
	bit                         shadow_empty;
	logic [cdq_pkg::CAP_W-1:0]  shadow_cap;

	int            mismatch_cnt = 0;
	int            gap_left = 0;
	int            stall_left = 0;
	int            calm_left [2] = '{0, 0};
	deque_op_t     next_op;
	deque_result_t got_exp;

	circular_deque_unit #(
		.DEPTH(STORE_DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out),
		.status    (status),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.capacity  (capacity)
	);

	always #6 clk = ~clk;

	// idle length for one side, with stretches of no idling
	function automatic int pause_len(input int side);
		int r;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) calm_left[side] = $urandom_range(20, 50);
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 20);
	endfunction

	function automatic void add_result(input logic signed [cdq_pkg::DATA_W-1:0] v,
			input cdq_pkg::status_t s, input logic l);
		deque_result_t e;
		e.value = v;
		e.st = s;
		e.last = l;
		predicted_results.push_back(e);
	endfunction

	// expected responses for one accepted request
	task automatic predict_deque_op(input logic [cdq_pkg::ACT_W-1:0] act,
			input logic signed [cdq_pkg::DATA_W-1:0] val);
		int unsigned cap;
		int unsigned idx;
		int unsigned k;
		bit          full;
		bit          stop;
		logic [cdq_pkg::DATA_W-1:0] rdata;
		cap = (shadow_cap == 0) ? 1 : ((shadow_cap > STORE_DEPTH) ? STORE_DEPTH : shadow_cap);
		full = !shadow_empty && ((shadow_rear + 1) % cap == shadow_front);
		case (act)
			cdq_pkg::ACT_INS_FRONT, cdq_pkg::ACT_INS_REAR: begin
				if (full) begin
					add_result('0, cdq_pkg::ST_OVERFLOW, 1'b1);
				end else begin
					if (shadow_empty) begin
						// first entry always lands at index zero
						shadow_front = 0;
						shadow_rear = 0;
						shadow_empty = 1'b0;
						shadow_store[0] = val;
					end else if (act == cdq_pkg::ACT_INS_FRONT) begin
						shadow_front = (shadow_front == 0) ? cap - 1 : shadow_front - 1;
						shadow_store[shadow_front] = val;
					end else begin
						shadow_rear = (shadow_rear + 1) % cap;
						shadow_store[shadow_rear] = val;
					end
					add_result('0, cdq_pkg::ST_OK, 1'b1);
				end
			end
			cdq_pkg::ACT_RM_FRONT, cdq_pkg::ACT_RM_REAR: begin
				if (shadow_empty) begin
					add_result('0, cdq_pkg::ST_UNDERFLOW, 1'b1);
				end else begin
					rdata = (act == cdq_pkg::ACT_RM_FRONT) ? shadow_store[shadow_front]
						: shadow_store[shadow_rear];
					if (shadow_front == shadow_rear) begin
						// last entry gone, indices back to zero
						shadow_empty = 1'b1;
						shadow_front = 0;
						shadow_rear = 0;
					end else if (act == cdq_pkg::ACT_RM_FRONT) begin
						shadow_front = (shadow_front + 1) % cap;
					end else begin
						shadow_rear = (shadow_rear == 0) ? cap - 1 : shadow_rear - 1;
					end
					add_result(rdata, cdq_pkg::ST_OK, 1'b1);
				end
			end
			cdq_pkg::ACT_READ_ALL: begin
				if (shadow_empty) begin
					add_result('0, cdq_pkg::ST_EMPTY, 1'b1);
				end else begin
					// walk front to rear, wrapping at capacity
					idx = shadow_front;
					k = 0;
					stop = 1'b0;
					while (!stop) begin
						stop = (idx == shadow_rear) || (k + 1 >= cap);
						add_result(shadow_store[idx], cdq_pkg::ST_OK, stop);
						k++;
						idx = (idx + 1) % cap;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic void push_op(input logic [cdq_pkg::ACT_W-1:0] a,
			input logic signed [cdq_pkg::DATA_W-1:0] v, input bit h);
		deque_op_t op;
		op.act = a;
		op.val = v;
		op.hold = h;
		pending_ops.push_back(op);
	endfunction

	// random requests; ignored actions do not count
	task automatic add_random_ops(input int count, input int ins_pct);
		int n;
		int r;
		logic [cdq_pkg::ACT_W-1:0] a;
		logic signed [cdq_pkg::DATA_W-1:0] v;
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			case ($urandom_range(0, 19))
				0: v = 32'sh8000_0000;
				1: v = 32'sh7fff_ffff;
				2: v = '0;
				3: v = -32'sd1;
				default: v = $urandom;
			endcase
			if (r < 3) begin
				push_op(act_val_t'($urandom_range(ACT_FIRST_UNUSED, ACT_MAX)), v, 1'b0);
			end else begin
				if (r < 9)
					a = cdq_pkg::ACT_READ_ALL;
				else if ($urandom_range(0, 99) < ins_pct)
					a = $urandom_range(0, 1) ? cdq_pkg::ACT_INS_REAR : cdq_pkg::ACT_INS_FRONT;
				else
					a = $urandom_range(0, 1) ? cdq_pkg::ACT_RM_REAR : cdq_pkg::ACT_RM_FRONT;
				push_op(a, v, $urandom_range(0, 49) == 0);
				n++;
			end
		end
	endtask

	// wait for all requests and responses, then let the block settle
	task automatic drain_and_settle();
		do @(negedge clk);
		while (pending_ops.size() != 0 || in_valid || predicted_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// capacity write, only while the block is idle
	task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] cap);
		@(posedge clk);
		cfg_valid <= 1'b1;
		capacity <= cap;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		shadow_cap = cap;
		shadow_empty = 1'b1;
		shadow_front = 0;
		shadow_rear = 0;
		@(negedge clk);
	endtask

	// drained flag sampled away from the active edge
	always @(negedge clk) begin
		results_drained <= (predicted_results.size() == 0);
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			// predict on each accepted transfer
			if (in_valid && !in_stall) predict_deque_op(action, value_in);
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() != 0 &&
						(!pending_ops[0].hold || (results_drained && !in_valid))) begin
					next_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					action <= next_op.act;
					value_in <= next_op.val;
					gap_left = pause_len(SIDE_IN);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					if (mismatch_cnt < MAX_REPORTS)
						$display("%0t: unexpected result value %h status %0d last %0d",
							$time, value_out, status, last);
					mismatch_cnt++;
				end else begin
					got_exp = predicted_results.pop_front();
					if (value_out !== got_exp.value || status !== got_exp.st ||
							last !== got_exp.last) begin
						if (mismatch_cnt < MAX_REPORTS)
							$display("%0t: mismatch exp value %h status %0d last %0d,",
								$time, got_exp.value, got_exp.st, got_exp.last,
								" got value %h status %0d last %0d",
								value_out, status, last);
						mismatch_cnt++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pause_len(SIDE_OUT);
			end
		end
	end

	// run time limit
	initial begin
		#50_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus phases
	initial begin
		foreach (shadow_store[i]) shadow_store[i] = '0;
		shadow_cap = cdq_pkg::CAP_RESET;
		shadow_empty = 1'b1;
		shadow_front = 0;
		shadow_rear = 0;

		// reset capacity: empty cases, wrap of both indices, ignored actions
		push_op(cdq_pkg::ACT_READ_ALL, '0, 1'b0);
		push_op(cdq_pkg::ACT_RM_FRONT, '0, 1'b0);
		push_op(cdq_pkg::ACT_RM_REAR, -32'sd1, 1'b0);
		push_op(cdq_pkg::ACT_INS_FRONT, 32'sh7fff_ffff, 1'b0);
		push_op(cdq_pkg::ACT_INS_FRONT, 32'sh8000_0000, 1'b0);
		push_op(cdq_pkg::ACT_INS_REAR, -32'sd1, 1'b0);
		push_op(cdq_pkg::ACT_READ_ALL, '0, 1'b0);
		push_op(cdq_pkg::ACT_RM_REAR, '0, 1'b0);
		push_op(cdq_pkg::ACT_RM_REAR, '0, 1'b0);
		push_op(cdq_pkg::ACT_RM_FRONT, '0, 1'b0);
		push_op(ACT_FIRST_UNUSED, 32'sh1234_5678, 1'b0);
		push_op(ACT_FIRST_UNUSED + 3'd1, -32'sd1, 1'b0);
		push_op(ACT_MAX, 32'sh7fff_ffff, 1'b1);
		push_op(cdq_pkg::ACT_INS_REAR, '0, 1'b0);
		push_op(cdq_pkg::ACT_RM_FRONT, '0, 1'b0);
		push_op(cdq_pkg::ACT_INS_REAR, 32'sd1, 1'b1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		drain_and_settle();

		// single entry deque: overflow both ways
		write_capacity(7'd1);
		push_op(cdq_pkg::ACT_INS_REAR, 32'sh5555_5555, 1'b0);
		push_op(cdq_pkg::ACT_INS_FRONT, 32'shaaaa_aaaa, 1'b0);
		push_op(cdq_pkg::ACT_INS_REAR, 32'sh0f0f_0f0f, 1'b0);
		push_op(cdq_pkg::ACT_READ_ALL, '0, 1'b0);
		push_op(cdq_pkg::ACT_RM_REAR, '0, 1'b0);
		push_op(cdq_pkg::ACT_READ_ALL, '0, 1'b0);
		add_random_ops(10, 50);
		drain_and_settle();

		// two entries: read-out across the wrap
		write_capacity(7'd2);
		push_op(cdq_pkg::ACT_INS_FRONT, 32'sh0000_00a5, 1'b0);
		push_op(cdq_pkg::ACT_INS_FRONT, 32'sh0000_005a, 1'b0);
		push_op(cdq_pkg::ACT_INS_REAR, 32'sh1111_1111, 1'b0);
		push_op(cdq_pkg::ACT_READ_ALL, '0, 1'b0);
		add_random_ops(10, 50);
		drain_and_settle();

		// zero capacity acts as one
		write_capacity(7'd0);
		add_random_ops(10, 50);
		drain_and_settle();

		// capacity above depth, filled well past full
		write_capacity(7'd127);
		add_random_ops(95, 95);
		drain_and_settle();

		write_capacity(cap_val_t'($urandom_range(3, 63)));
		add_random_ops(25, 55);
		drain_and_settle();

		write_capacity(7'd64);
		add_random_ops(10, 60);
		drain_and_settle();

		if (mismatch_cnt == 0 && predicted_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> sim.f
design/cdq_pkg.sv
design/cdq_ctrl.sv
design/cdq_dp.sv
design/circular_deque_unit.sv
test/tb.sv
